/* sv/scf_pkg.sv */
// ----------------------------------------------------------------------------
// scf_pkg
// Shared types and constants of the substitution cipher FIFO: request and
// status codes, controller states, and the command and status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package scf_pkg;

    localparam int TABLE_LEN = 52;
    localparam int HALF_LEN  = 26;
    localparam int TBL_AW    = 6;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_PUSH = 2'd1;
    localparam logic [1:0] REQ_POP  = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ENC_WAIT,
        ST_POP_WAIT,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        TRD_ENC,
        TRD_FIRST,
        TRD_NEXT
    } trd_sel_t;

    typedef enum logic [2:0] {
        RES_OK,
        RES_FULL,
        RES_EMPTY,
        RES_FIFO,
        RES_MATCH
    } res_sel_t;

    typedef struct packed {
        logic     capture;
        logic     tbl_write;
        trd_sel_t trd_sel;
        logic     push;
        logic     push_from_tbl;
        logic     pop;
        logic     res_load;
        res_sel_t res_sel;
        logic     scan_clear;
        logic     scan_step;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       mode;
        logic       full;
        logic       empty;
        logic       char_letter;
        logic       idx_ok;
        logic       pop_letter;
        logic       scan_match;
        logic       scan_last;
        logic       out_free;
    } stat_t;

endpackage

`default_nettype wire

/* sv/substitution_cipher_fifo.sv */
// ----------------------------------------------------------------------------
// substitution_cipher_fifo
// Byte FIFO with a loadable 52-entry letter substitution table.
// Requests enter on the s_ stream: tuser carries the request type (load a
// table entry, push a byte, pop a byte), tdata the byte and table index.
// Every request gives exactly one result on the m_ stream: tdata carries
// the popped byte and the fill level after the request, tuser the status.
// The mode register on the APB port selects encoding on push or decoding
// on pop; write it only while the block is idle.
// Requests are handled one at a time. After the accepting edge, loads,
// refused requests and raw pushes pass EXEC and DONE to the output register,
// encoding pushes and plain pops also pass ENC_WAIT or POP_WAIT (one registered
// memory read), and decoding pops then scan the table one entry per cycle up
// to the first match or the last entry; the next request is taken from IDLE.
// The output register holds a result while m_tready is low; the next
// request is still accepted and completes up to the output register.
// Reset empties the FIFO and clears mode to encoding; table and FIFO
// contents are undefined until written, and the table must be loaded
// before it is used.
// ----------------------------------------------------------------------------
`default_nettype none

module substitution_cipher_fifo #(
    parameter int BUF_DEPTH = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // Request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] in_char, [13:8] table_index, [15:14] zero
    input  wire logic [1:0]  s_tuser,   // [1:0] req_type
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] out_char, [14:8] fill_level, [15] zero
    output logic [1:0]       m_tuser    // [1:0] status
);

    logic           mode_reg;
    logic           mode_next;
    scf_pkg::cmd_t  cmd;
    scf_pkg::stat_t stat;
    logic [7:0]     out_char;
    logic [6:0]     fill_level;
    logic           cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && !paddr[2];
    assign mode_next = cfg_write ? pwdata[0] : mode_reg;
    assign prdata    = paddr[2] ? 32'd0 : {31'd0, mode_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= scf_pkg::MODE_ENCODE;
        end else begin
            mode_reg <= mode_next;
        end
    end

    scf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    scf_datapath #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .mode           (mode_reg),
        .in_req_type    (s_tuser),
        .in_char        (s_tdata[7:0]),
        .in_table_index (s_tdata[13:8]),
        .cmd            (cmd),
        .stat           (stat),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .m_out_char     (out_char),
        .m_status       (m_tuser),
        .m_fill_level   (fill_level)
    );

    assign m_tdata = {1'b0, fill_level, out_char};

endmodule

`default_nettype wire

/* sv/scf_ram.sv */
// ----------------------------------------------------------------------------
// scf_ram
// Generic single-clock RAM with one write port and one read port. Read data
// is registered and appears in the cycle after the address.
// ----------------------------------------------------------------------------
`default_nettype none

module scf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* sv/scf_ctrl.sv */
// ----------------------------------------------------------------------------
// scf_ctrl
// Controller of the substitution cipher FIFO. It takes one request at a
// time, steps the datapath through table and FIFO accesses and the decode
// scan, and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module scf_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire scf_pkg::stat_t stat,
    output scf_pkg::cmd_t      cmd
);

    scf_pkg::state_t state_reg;
    scf_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= scf_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            scf_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = scf_pkg::ST_EXEC;
                end
            end
            scf_pkg::ST_EXEC: begin
                state_next = scf_pkg::ST_DONE;
                if (stat.req == scf_pkg::REQ_PUSH && !stat.full &&
                    stat.mode == scf_pkg::MODE_ENCODE && stat.char_letter) begin
                    state_next = scf_pkg::ST_ENC_WAIT;
                end else if (stat.req == scf_pkg::REQ_POP && !stat.empty) begin
                    state_next = scf_pkg::ST_POP_WAIT;
                end
            end
            scf_pkg::ST_ENC_WAIT: begin
                state_next = scf_pkg::ST_DONE;
            end
            scf_pkg::ST_POP_WAIT: begin
                if (stat.mode == scf_pkg::MODE_DECODE && stat.pop_letter) begin
                    state_next = scf_pkg::ST_SCAN;
                end else begin
                    state_next = scf_pkg::ST_DONE;
                end
            end
            scf_pkg::ST_SCAN: begin
                if (stat.scan_match || stat.scan_last) begin
                    state_next = scf_pkg::ST_DONE;
                end
            end
            scf_pkg::ST_DONE: begin
                if (stat.out_free) begin
                    state_next = scf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = scf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.trd_sel  = scf_pkg::TRD_ENC;
        cmd.res_sel  = scf_pkg::RES_OK;
        s_tready     = 1'b0;
        unique case (state_reg)
            scf_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            scf_pkg::ST_EXEC: begin
                priority if (stat.req == scf_pkg::REQ_LOAD) begin
                    cmd.tbl_write = stat.idx_ok;
                    cmd.res_load  = 1'b1;
                end else if (stat.req == scf_pkg::REQ_PUSH) begin
                    priority if (stat.full) begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = scf_pkg::RES_FULL;
                    end else if (stat.mode == scf_pkg::MODE_ENCODE && stat.char_letter) begin
                        cmd.trd_sel = scf_pkg::TRD_ENC;
                    end else begin
                        cmd.push     = 1'b1;
                        cmd.res_load = 1'b1;
                    end
                end else if (stat.req == scf_pkg::REQ_POP) begin
                    if (stat.empty) begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = scf_pkg::RES_EMPTY;
                    end else begin
                        cmd.pop = 1'b1;
                    end
                end else begin
                    cmd.res_load = 1'b1;
                end
            end
            scf_pkg::ST_ENC_WAIT: begin
                cmd.push          = 1'b1;
                cmd.push_from_tbl = 1'b1;
                cmd.res_load      = 1'b1;
            end
            scf_pkg::ST_POP_WAIT: begin
                cmd.res_load   = 1'b1;
                cmd.res_sel    = scf_pkg::RES_FIFO;
                cmd.trd_sel    = scf_pkg::TRD_FIRST;
                cmd.scan_clear = 1'b1;
            end
            scf_pkg::ST_SCAN: begin
                if (stat.scan_match) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = scf_pkg::RES_MATCH;
                end else if (!stat.scan_last) begin
                    cmd.scan_step = 1'b1;
                    cmd.trd_sel   = scf_pkg::TRD_NEXT;
                end
            end
            scf_pkg::ST_DONE: begin
                cmd.out_load = stat.out_free;
            end
            default: begin
                cmd.out_load = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/scf_datapath.sv */
// ----------------------------------------------------------------------------
// scf_datapath
// Datapath of the substitution cipher FIFO: request registers, the table
// and FIFO memories, pointers and fill count, the decode scan index, the
// result registers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module scf_datapath #(
    parameter int BUF_DEPTH = 64
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          mode,
    input  wire logic [1:0]    in_req_type,
    input  wire logic [7:0]    in_char,
    input  wire logic [5:0]    in_table_index,
    input  wire scf_pkg::cmd_t cmd,
    output scf_pkg::stat_t     stat,
    input  wire logic          m_tready,
    output logic               m_tvalid,
    output logic [7:0]         m_out_char,
    output logic [1:0]         m_status,
    output logic [6:0]         m_fill_level
);

    localparam int PTR_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int CNT_W = $clog2(BUF_DEPTH + 1);

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= scf_pkg::CHAR_UPPER_A && c <= scf_pkg::CHAR_UPPER_Z) ||
               (c >= scf_pkg::CHAR_LOWER_A && c <= scf_pkg::CHAR_LOWER_Z);
    endfunction

    logic [1:0]               req_reg,        req_next;
    logic [7:0]               char_reg,       char_next;
    logic [5:0]               idx_reg,        idx_next;
    logic [PTR_W-1:0]         wptr_reg,       wptr_next;
    logic [PTR_W-1:0]         rptr_reg,       rptr_next;
    logic [CNT_W-1:0]         fill_reg,       fill_next;
    logic [scf_pkg::TBL_AW-1:0] scan_reg,     scan_next;
    logic [7:0]               res_char_reg,   res_char_next;
    logic [1:0]               res_status_reg, res_status_next;
    logic                     out_valid_reg,  out_valid_next;
    logic [7:0]               out_char_reg,   out_char_next;
    logic [1:0]               out_status_reg, out_status_next;
    logic [6:0]               out_fill_reg,   out_fill_next;

    logic [scf_pkg::TBL_AW-1:0] tbl_raddr;
    logic [scf_pkg::TBL_AW-1:0] enc_addr;
    logic [7:0]                 tbl_rdata;
    logic [7:0]                 fifo_rdata;
    logic [7:0]                 fifo_wdata;
    logic [7:0]                 match_char;
    logic [CNT_W+6:0]           fill_ext;

    scf_ram #(
        .WIDTH (8),
        .DEPTH (scf_pkg::TABLE_LEN),
        .AW    (scf_pkg::TBL_AW)
    ) u_table (
        .aclk  (aclk),
        .we    (cmd.tbl_write),
        .waddr (idx_reg),
        .wdata (char_reg),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    scf_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH),
        .AW    (PTR_W)
    ) u_fifo (
        .aclk  (aclk),
        .we    (cmd.push),
        .waddr (wptr_reg),
        .wdata (fifo_wdata),
        .raddr (rptr_reg),
        .rdata (fifo_rdata)
    );

    always_comb begin
        if (char_reg >= scf_pkg::CHAR_LOWER_A) begin
            enc_addr = scf_pkg::TBL_AW'(char_reg - scf_pkg::CHAR_LOWER_A);
        end else begin
            enc_addr = scf_pkg::TBL_AW'(char_reg - scf_pkg::CHAR_UPPER_A
                                        + 8'(scf_pkg::HALF_LEN));
        end
    end

    always_comb begin
        unique case (cmd.trd_sel)
            scf_pkg::TRD_ENC:   tbl_raddr = enc_addr;
            scf_pkg::TRD_FIRST: tbl_raddr = '0;
            scf_pkg::TRD_NEXT:  tbl_raddr = scan_reg + 1'b1;
            default:            tbl_raddr = enc_addr;
        endcase
    end

    always_comb begin
        if (scan_reg < scf_pkg::TBL_AW'(scf_pkg::HALF_LEN)) begin
            match_char = scf_pkg::CHAR_LOWER_A + {2'b00, scan_reg};
        end else begin
            match_char = scf_pkg::CHAR_UPPER_A + {2'b00, scan_reg}
                         - 8'(scf_pkg::HALF_LEN);
        end
    end

    assign fifo_wdata = cmd.push_from_tbl ? tbl_rdata : char_reg;
    assign fill_ext   = (CNT_W + 7)'(fill_next);

    always_comb begin
        req_next        = req_reg;
        char_next       = char_reg;
        idx_next        = idx_reg;
        wptr_next       = wptr_reg;
        rptr_next       = rptr_reg;
        fill_next       = fill_reg;
        scan_next       = scan_reg;
        res_char_next   = res_char_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_char_next   = out_char_reg;
        out_status_next = out_status_reg;
        out_fill_next   = out_fill_reg;

        if (cmd.capture) begin
            req_next  = in_req_type;
            char_next = in_char;
            idx_next  = in_table_index;
        end
        if (cmd.push) begin
            wptr_next = (wptr_reg == PTR_W'(BUF_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            fill_next = fill_reg + 1'b1;
        end
        if (cmd.pop) begin
            rptr_next = (rptr_reg == PTR_W'(BUF_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            fill_next = fill_reg - 1'b1;
        end
        if (cmd.scan_clear) begin
            scan_next = '0;
        end else if (cmd.scan_step) begin
            scan_next = scan_reg + 1'b1;
        end
        if (cmd.res_load) begin
            unique case (cmd.res_sel)
                scf_pkg::RES_OK: begin
                    res_char_next   = '0;
                    res_status_next = scf_pkg::STAT_OK;
                end
                scf_pkg::RES_FULL: begin
                    res_char_next   = '0;
                    res_status_next = scf_pkg::STAT_FULL;
                end
                scf_pkg::RES_EMPTY: begin
                    res_char_next   = '0;
                    res_status_next = scf_pkg::STAT_EMPTY;
                end
                scf_pkg::RES_FIFO: begin
                    res_char_next   = fifo_rdata;
                    res_status_next = scf_pkg::STAT_OK;
                end
                scf_pkg::RES_MATCH: begin
                    res_char_next   = match_char;
                    res_status_next = scf_pkg::STAT_OK;
                end
                default: begin
                    res_char_next   = '0;
                    res_status_next = scf_pkg::STAT_OK;
                end
            endcase
        end
        if (cmd.out_load) begin
            out_valid_next  = 1'b1;
            out_char_next   = res_char_reg;
            out_status_next = res_status_reg;
            out_fill_next   = fill_ext[6:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg      <= '0;
            rptr_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            wptr_reg      <= wptr_next;
            rptr_reg      <= rptr_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        char_reg       <= char_next;
        idx_reg        <= idx_next;
        scan_reg       <= scan_next;
        res_char_reg   <= res_char_next;
        res_status_reg <= res_status_next;
        out_char_reg   <= out_char_next;
        out_status_reg <= out_status_next;
        out_fill_reg   <= out_fill_next;
    end

    always_comb begin
        stat.req         = req_reg;
        stat.mode        = mode;
        stat.full        = (fill_reg == CNT_W'(BUF_DEPTH));
        stat.empty       = (fill_reg == '0);
        stat.char_letter = is_letter(char_reg);
        stat.idx_ok      = (idx_reg < scf_pkg::TBL_AW'(scf_pkg::TABLE_LEN));
        stat.pop_letter  = is_letter(fifo_rdata);
        stat.scan_match  = (tbl_rdata == res_char_reg);
        stat.scan_last   = (scan_reg == scf_pkg::TBL_AW'(scf_pkg::TABLE_LEN - 1));
        stat.out_free    = !out_valid_reg || m_tready;
    end

    assign m_tvalid     = out_valid_reg;
    assign m_out_char   = out_char_reg;
    assign m_status     = out_status_reg;
    assign m_fill_level = out_fill_reg;

endmodule

`default_nettype wire
